/* rtl/core/fdss_pkg.sv */
// Shared types, constants and functions for the four-digit seven-segment scanner.
`timescale 1ns / 1ps
`default_nettype none

package fdss_pkg;

    // Command codes carried in the command field of an input word.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // View modes. Codes above plain view are kept and display like plain view.
    localparam logic [2:0] VIEW_TIME        = 3'd0;
    localparam logic [2:0] VIEW_TEMPERATURE = 3'd1;
    localparam logic [2:0] VIEW_DATE        = 3'd2;
    localparam logic [2:0] VIEW_DAY         = 3'd3;
    localparam logic [2:0] VIEW_PLAIN       = 3'd4;

    // Glyph codes beyond the decimal digits.
    localparam logic [3:0] GLYPH_DASH  = 4'd10;
    localparam logic [3:0] GLYPH_C     = 4'd11;
    localparam logic [3:0] GLYPH_BLANK = 4'd12;

    // Largest number the display holds; larger numbers saturate to it.
    localparam logic [13:0] NUMBER_MAX = 14'd9999;

    // Decimal point bit in the segment byte.
    localparam logic [7:0] SEG_DP = 8'h80;

    // Input word.
    typedef struct packed {
        logic        command;
        logic [13:0] number;
        logic [2:0]  view_mode;
        logic        edit_minutes;
        logic        blink_phase;
    } fdss_cmd_t;

    // Output word.
    typedef struct packed {
        logic [3:0] digit_enable;
        logic [7:0] segments;
    } fdss_disp_t;

    // Active-high segment pattern, bit 6 g down to bit 0 a.
    function automatic logic [7:0] glyph_bits(input logic [3:0] g);
        logic [7:0] s;
        case (g)
            4'd0:        s = 8'b0011_1111;
            4'd1:        s = 8'b0000_0110;
            4'd2:        s = 8'b0101_1011;
            4'd3:        s = 8'b0100_1111;
            4'd4:        s = 8'b0110_0110;
            4'd5:        s = 8'b0110_1101;
            4'd6:        s = 8'b0111_1101;
            4'd7:        s = 8'b0000_0111;
            4'd8:        s = 8'b0111_1111;
            4'd9:        s = 8'b0110_1111;
            GLYPH_DASH:  s = 8'b0100_0000;
            GLYPH_C:     s = 8'b0011_1001;
            GLYPH_BLANK: s = 8'b0000_0000;
            default:     s = 8'b0000_0000;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/fdss_digit_split.sv */
// Combinational saturation and decimal digit split of a loaded number.
`timescale 1ns / 1ps
`default_nettype none

module fdss_digit_split (
    input  wire logic [13:0]     number,
    output logic      [3:0][3:0] digits
);

    // Reciprocal multipliers, rounded up; exact quotients for every number up to 9999.
    localparam logic [13:0] RECIP_10   = 14'd13108;
    localparam logic [13:0] RECIP_100  = 14'd5243;
    localparam logic [13:0] RECIP_1000 = 14'd8389;

    logic [13:0] sat_num;
    logic [26:0] prod_10;
    logic [25:0] prod_100;
    logic [26:0] prod_1000;
    logic [9:0]  quot_10;
    logic [6:0]  quot_100;
    logic [3:0]  quot_1000;

    // The three quotients come from parallel constant multiplies; each low digit is
    // the number or a quotient minus ten times the next; digit 3 is a quotient.
    always_comb
    begin
        sat_num   = (number > fdss_pkg::NUMBER_MAX) ? fdss_pkg::NUMBER_MAX : number;
        prod_10   = 27'(sat_num) * 27'(RECIP_10);
        prod_100  = 26'(sat_num) * 26'(RECIP_100);
        prod_1000 = 27'(sat_num) * 27'(RECIP_1000);
        quot_10   = prod_10[26:17];
        quot_100  = prod_100[25:19];
        quot_1000 = prod_1000[26:23];
        digits[0] = 4'(sat_num - 14'(quot_10) * 14'd10);
        digits[1] = 4'(quot_10 - 10'(quot_100) * 10'd10);
        digits[2] = 4'(quot_100 - 7'(quot_1000) * 7'd10);
        digits[3] = quot_1000;
    end

endmodule

`default_nettype wire

/* rtl/core/fdss_render.sv */
// Display state, scan counter and segment rendering with the output register.
`timescale 1ns / 1ps
`default_nettype none

module fdss_render (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire fdss_pkg::fdss_cmd_t   item,
    input  wire logic [3:0][3:0]       item_digits,
    output logic                       disp_valid,
    input  wire logic                  disp_stall,
    output fdss_pkg::fdss_disp_t       disp_data
);

    logic [1:0]       scan_reg;
    logic [3:0][3:0]  digits_reg;
    logic [2:0]       view_reg;
    logic             out_valid_reg;
    fdss_pkg::fdss_disp_t out_reg, out_next;
    logic             out_free;
    logic             load_fire, tick_fire;
    logic             blank_pair;
    logic [3:0]       glyph;

    // Loads never wait; ticks wait for room in the output register.
    assign out_free   = !out_valid_reg || !disp_stall;
    assign item_ready = (item.command == fdss_pkg::CMD_LOAD) || out_free;
    assign load_fire  = item_valid && (item.command == fdss_pkg::CMD_LOAD);
    assign tick_fire  = item_valid && (item.command == fdss_pkg::CMD_TICK) && out_free;

    // Pick the glyph and enable for the digit under scan.
    always_comb
    begin
        blank_pair            = item.edit_minutes && !item.blink_phase;
        out_next.digit_enable = 4'b0001 << scan_reg;
        glyph                 = digits_reg[scan_reg];
        case (scan_reg)
            2'd0:
            begin
                if (view_reg == fdss_pkg::VIEW_DAY)
                begin
                    glyph = fdss_pkg::GLYPH_DASH;
                end
                else if (view_reg == fdss_pkg::VIEW_TEMPERATURE)
                begin
                    glyph = fdss_pkg::GLYPH_C;
                end
                if (blank_pair)
                begin
                    out_next.digit_enable = 4'b0000;
                end
            end
            2'd1:
            begin
                if (blank_pair)
                begin
                    out_next.digit_enable = 4'b0000;
                end
            end
            2'd2:
            begin
                if (view_reg == fdss_pkg::VIEW_DAY)
                begin
                    glyph = fdss_pkg::GLYPH_DASH;
                end
            end
            default:
            begin
                if (view_reg == fdss_pkg::VIEW_DAY)
                begin
                    glyph = fdss_pkg::GLYPH_BLANK;
                end
            end
        endcase
        out_next.segments = fdss_pkg::glyph_bits(glyph);
        // Digit 2 carries the decimal point in some views.
        if ((scan_reg == 2'd2) &&
            (((view_reg == fdss_pkg::VIEW_TIME) && !item.blink_phase) ||
             (view_reg == fdss_pkg::VIEW_DATE) ||
             (view_reg == fdss_pkg::VIEW_TEMPERATURE)))
        begin
            out_next.segments = out_next.segments | fdss_pkg::SEG_DP;
        end
    end

    // Display state and scan position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg      <= 2'd0;
            digits_reg    <= '0;
            view_reg      <= fdss_pkg::VIEW_TIME;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_fire)
            begin
                digits_reg <= item_digits;
                view_reg   <= item.view_mode;
            end
            if (tick_fire)
            begin
                scan_reg <= scan_reg + 2'd1;
            end
            if (out_free)
            begin
                out_valid_reg <= tick_fire;
            end
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            out_reg <= out_next;
        end
    end

    assign disp_valid = out_valid_reg;
    assign disp_data  = out_reg;

endmodule

`default_nettype wire

/* rtl/core/four_digit_seven_segment_scanner_unit.sv */
// Top level of the four-digit seven-segment scanner.
//
// The cmd channel (cmd_valid, cmd_stall, cmd_data) takes one word per cycle
// while cmd_stall is low. A load word saturates its number to 9999, splits
// it into four decimal digits kept with the view mode and gives no output.
// A tick word renders the digit under scan (0, 1, 2, 3, 0, ...) and gives
// one word on the disp channel (disp_valid, disp_stall, disp_data): a
// one-hot or zero digit enable and an active-high segment byte, dp in bit 7.
// A tick word reaches disp_valid through the input register and then the
// output register. Throughput is one word per cycle while no stall holds the
// flow, set by the single pass of combinational logic between the two
// registers. A load leaves the input register in the next cycle even while
// the output word is stalled.
// While disp_stall is high a valid output word holds; a tick waiting in the
// input register stays there and cmd_stall is high until the output frees.
// Reset clears both valid flags, the scan position, the stored digits to
// zero and the view to time view.
`timescale 1ns / 1ps
`default_nettype none

module four_digit_seven_segment_scanner_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_stall,
    input  wire fdss_pkg::fdss_cmd_t  cmd_data,
    output logic                      disp_valid,
    input  wire logic                 disp_stall,
    output fdss_pkg::fdss_disp_t      disp_data
);

    logic                  in_valid_reg;
    fdss_pkg::fdss_cmd_t   in_reg;
    logic                  in_ready;
    logic                  render_ready;
    logic [3:0][3:0]       load_digits;

    // Input register takes a word when empty or when its word moves on.
    assign in_ready  = !in_valid_reg || render_ready;
    assign cmd_stall = !in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && cmd_valid)
        begin
            in_reg <= cmd_data;
        end
    end

    // Decimal digits of the number held in the input register.
    fdss_digit_split u_split (
        .number (in_reg.number),
        .digits (load_digits)
    );

    // Display state and rendering.
    fdss_render u_render (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (in_valid_reg),
        .item_ready  (render_ready),
        .item        (in_reg),
        .item_digits (load_digits),
        .disp_valid  (disp_valid),
        .disp_stall  (disp_stall),
        .disp_data   (disp_data)
    );

endmodule

`default_nettype wire

/* verif/four_digit_seven_segment_scanner_unit_tb.sv */
// Self-checking testbench for the four-digit seven-segment scanner with a behavioral display model.
`timescale 1ns / 1ps

module four_digit_seven_segment_scanner_unit_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_WORDS = 550;
    localparam int DRAIN_CYCLES = 10;

    // Segment patterns indexed by glyph code; entry 0 is the rightmost byte.
    localparam logic [12:0][7:0] GLYPH_ROM = {
        8'h00, 8'h39, 8'h40, 8'h6F, 8'h7F, 8'h07, 8'h7D,
        8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cmd_valid;
    logic                 cmd_stall;
    fdss_pkg::fdss_cmd_t  cmd_data;
    logic                 disp_valid;
    logic                 disp_stall;
    fdss_pkg::fdss_disp_t disp_data;

    // Display model state.
    logic [1:0] scan_pos;
    logic [3:0] digit_store [4];
    logic [2:0] shown_view;
    fdss_pkg::fdss_disp_t pending_frames [$];

    int err_count;
    int checked_count;
    int load_count;
    int tick_count;
    int quiet_cycles;

    four_digit_seven_segment_scanner_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_data   (cmd_data),
        .disp_valid (disp_valid),
        .disp_stall (disp_stall),
        .disp_data  (disp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    function automatic fdss_pkg::fdss_cmd_t make_word(input logic c, input logic [13:0] n,
                                                      input logic [2:0] v, input logic e,
                                                      input logic b);
        fdss_pkg::fdss_cmd_t w;
        w.command      = c;
        w.number       = n;
        w.view_mode    = v;
        w.edit_minutes = e;
        w.blink_phase  = b;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0t] mismatch on %s: got %02h, expected %02h", $time, what, got, want);
        err_count++;
    endtask

    // Advance the display model by one accepted word.
    task automatic track_word(input fdss_pkg::fdss_cmd_t w);
        int                   n;
        logic [3:0]           g;
        logic                 blank_pair;
        fdss_pkg::fdss_disp_t f;
        if (w.command == fdss_pkg::CMD_LOAD)
        begin
            n = (w.number > fdss_pkg::NUMBER_MAX) ? int'(fdss_pkg::NUMBER_MAX)
                                                  : int'(w.number);
            digit_store[0] = 4'(n % 10);
            digit_store[1] = 4'((n / 10) % 10);
            digit_store[2] = 4'((n / 100) % 10);
            digit_store[3] = 4'(n / 1000);
            shown_view = w.view_mode;
            load_count++;
        end
        else
        begin
            blank_pair = w.edit_minutes && !w.blink_phase;
            f.digit_enable = 4'b0001 << scan_pos;
            case (scan_pos)
                2'd0:
                begin
                    if (shown_view == fdss_pkg::VIEW_DAY)
                        g = fdss_pkg::GLYPH_DASH;
                    else if (shown_view == fdss_pkg::VIEW_TEMPERATURE)
                        g = fdss_pkg::GLYPH_C;
                    else
                        g = digit_store[0];
                    if (blank_pair)
                        f.digit_enable = 4'b0000;
                end
                2'd1:
                begin
                    g = digit_store[1];
                    if (blank_pair)
                        f.digit_enable = 4'b0000;
                end
                2'd2:
                    g = (shown_view == fdss_pkg::VIEW_DAY) ? fdss_pkg::GLYPH_DASH
                                                           : digit_store[2];
                default:
                    g = (shown_view == fdss_pkg::VIEW_DAY) ? fdss_pkg::GLYPH_BLANK
                                                           : digit_store[3];
            endcase
            f.segments = GLYPH_ROM[g];
            // Only the hundreds digit can carry a decimal point.
            if (scan_pos == 2'd2 &&
                ((shown_view == fdss_pkg::VIEW_TIME && !w.blink_phase) ||
                 shown_view == fdss_pkg::VIEW_DATE ||
                 shown_view == fdss_pkg::VIEW_TEMPERATURE))
                f.segments = f.segments | fdss_pkg::SEG_DP;
            pending_frames.push_back(f);
            scan_pos = scan_pos + 2'd1;
            tick_count++;
        end
    endtask

    // Present one word, hold it until taken, then idle for a random gap.
    task automatic send_word(input fdss_pkg::fdss_cmd_t w);
        int gap;
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_data  <= w;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        track_word(w);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop sending and let every pending display word come out.
    task automatic wait_for_idle();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Scan out of reset: zeros in time view, blink both ways.
    task automatic test_power_up_scan();
        for (int i = 0; i < 4; i++)
            send_word(make_word(fdss_pkg::CMD_TICK, 14'd0, fdss_pkg::VIEW_TIME, 1'b0, i[1]));
    endtask

    // Full-scale number saturates; blanking both ways and the lit time-view dot.
    task automatic test_saturation();
        send_word(make_word(fdss_pkg::CMD_LOAD, 14'h3FFF, fdss_pkg::VIEW_TIME, 1'b0, 1'b0));
        send_word(make_word(fdss_pkg::CMD_TICK, 14'h3FFF, fdss_pkg::VIEW_TIME, 1'b1, 1'b1));
        send_word(make_word(fdss_pkg::CMD_TICK, 14'h3FFF, fdss_pkg::VIEW_TIME, 1'b1, 1'b0));
        send_word(make_word(fdss_pkg::CMD_TICK, 14'h3FFF, fdss_pkg::VIEW_TIME, 1'b0, 1'b0));
        send_word(make_word(fdss_pkg::CMD_TICK, 14'h3FFF, fdss_pkg::VIEW_TIME, 1'b0, 1'b1));
    endtask

    // Day view: dashes on digits 0 and 2, blank on digit 3.
    task automatic test_day_view();
        send_word(make_word(fdss_pkg::CMD_LOAD, 14'd0, fdss_pkg::VIEW_DAY, 1'b1, 1'b1));
        for (int i = 0; i < 4; i++)
            send_word(make_word(fdss_pkg::CMD_TICK, 14'd0, fdss_pkg::VIEW_DAY, 1'b0, i[0]));
    endtask

    // Temperature view: 'C' on digit 0 and a lit dot on digit 2.
    task automatic test_temperature_view();
        send_word(make_word(fdss_pkg::CMD_LOAD, 14'd1234, fdss_pkg::VIEW_TEMPERATURE,
                            1'b0, 1'b0));
        for (int i = 0; i < 4; i++)
            send_word(make_word(fdss_pkg::CMD_TICK, 14'd0, fdss_pkg::VIEW_TEMPERATURE,
                                1'b0, 1'b1));
    endtask

    // Date view just above range, with both low digits blanked.
    task automatic test_date_edit_blank();
        send_word(make_word(fdss_pkg::CMD_LOAD, 14'd10000, fdss_pkg::VIEW_DATE, 1'b0, 1'b0));
        for (int i = 0; i < 4; i++)
            send_word(make_word(fdss_pkg::CMD_TICK, 14'd0, fdss_pkg::VIEW_DATE, 1'b1, 1'b0));
    endtask

    // Random mix of loads and ticks, every view code, numbers in and above range.
    task automatic test_random_mix(input int count);
        logic [13:0] n;
        logic        c;
        for (int i = 0; i < count; i++)
        begin
            c = ($urandom_range(99) < 20) ? fdss_pkg::CMD_LOAD : fdss_pkg::CMD_TICK;
            if ($urandom_range(99) < 85)
                n = 14'($urandom_range(int'(fdss_pkg::NUMBER_MAX)));
            else
                n = 14'($urandom_range(16383, int'(fdss_pkg::NUMBER_MAX) + 1));
            send_word(make_word(c, n, 3'($urandom_range(7)),
                                1'($urandom_range(1)), 1'($urandom_range(1))));
        end
    endtask

    // Sender holds off until the display side has caught up.
    task automatic test_drain_pause();
        wait_for_idle();
    endtask

    // Receiver pacing: random runs with no stall, each followed by a random stall that may be empty.
    initial
    begin : rx_pacing
        int run_len;
        disp_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            run_len = $urandom_range(24, 1);
            @(negedge clk);
            disp_stall <= 1'b0;
            repeat (run_len - 1) @(negedge clk);
            run_len = pick_gap();
            if (run_len > 0)
            begin
                @(negedge clk);
                disp_stall <= 1'b1;
                repeat (run_len - 1) @(negedge clk);
            end
        end
    end

    // Compare each display word taken with the oldest pending prediction.
    always @(posedge clk)
    begin : frame_check
        fdss_pkg::fdss_disp_t want;
        if (rst_n && disp_valid && !disp_stall)
        begin
            if (pending_frames.size() == 0)
            begin
                report_mismatch("unexpected display word", disp_data.segments, 8'h00);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (disp_data.digit_enable !== want.digit_enable)
                    report_mismatch("digit_enable", 8'(disp_data.digit_enable),
                                    8'(want.digit_enable));
                if (disp_data.segments !== want.segments)
                    report_mismatch("segments", disp_data.segments, want.segments);
                checked_count++;
            end
        end
    end

    // End the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (disp_valid && !disp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : main_sequence
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd_data      = '0;
        err_count     = 0;
        checked_count = 0;
        load_count    = 0;
        tick_count    = 0;
        quiet_cycles  = 0;
        scan_pos      = 2'd0;
        shown_view    = fdss_pkg::VIEW_TIME;
        for (int i = 0; i < 4; i++)
            digit_store[i] = 4'd0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_power_up_scan();
        test_saturation();
        test_day_view();
        test_temperature_view();
        test_date_edit_blank();
        test_random_mix(RANDOM_WORDS / 2);
        test_drain_pause();
        test_random_mix(RANDOM_WORDS - RANDOM_WORDS / 2);
        wait_for_idle();

        $display("Sent %0d loads and %0d ticks over all view codes, with saturation,",
                 load_count, tick_count);
        $display("blanking and random stalls on both sides; %0d display words checked.",
                 checked_count);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
